// ===== rtl/bdss_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded-displacement stream sorter package
// Shared constants, transaction payload types and sorter cell types.
// ----------------------------------------------------------------------------
package bdss_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int WINDOW_DEF = 20;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last_in;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         last_out;
        logic                         order_error;
    } out_t;

    // One window entry, held as an order key (sign bit inverted).
    typedef struct packed {
        logic                  valid;
        logic [DATA_WIDTH-1:0] key;
    } entry_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic en;
        logic ins_en;
        logic shift;
    } cell_ctl_t;

    function automatic logic [DATA_WIDTH-1:0] to_key(input logic [DATA_WIDTH-1:0] v);
        return v ^ {1'b1, {(DATA_WIDTH-1){1'b0}}};
    endfunction

endpackage

// ===== rtl/bdss_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded-displacement stream sorter cell
// Holds one window entry; inserts the broadcast key and shifts toward the head.
// ----------------------------------------------------------------------------
module bdss_cell
    import bdss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] new_key,
    input  entry_t                left_cur,
    input  logic                  left_gt,
    input  entry_t                right_ins,
    output entry_t                cur,
    output logic                  gt,
    output entry_t                ins
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] key_next;

    assign cur.valid = valid_reg;
    assign cur.key   = key_reg;

    // An empty cell counts as larger than any key; ties keep arrival order.
    assign gt = !valid_reg || (key_reg > new_key);

    always_comb begin
        ins = cur;
        if (ctl.ins_en && gt) begin
            if (left_gt) begin
                ins = left_cur;
            end else begin
                ins.valid = 1'b1;
                ins.key   = new_key;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (ctl.en) begin
            if (ctl.shift) begin
                valid_next = right_ins.valid;
                key_next   = right_ins.key;
            end else begin
                valid_next = ins.valid;
                key_next   = ins.key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// ===== rtl/bounded_displacement_stream_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// Bounded-displacement stream sorter
// Sorts a nearly ordered stream through a systolic insertion window.
//
//   Channel  Direction  Payload  Handshake
//   s_       in         in_t     s_valid / s_ready
//   m_       out        out_t    m_valid / m_ready
//
// A transaction that does not end a stream is inserted into the window; once
// the window is full, the cycle that takes it also registers the smallest entry.
// A transaction marked last is inserted, then the window drains one result per
// cycle (up to WINDOW results) while the single output register is free.
// Reset is synchronous and empties the window. A stalled output holds the
// input off until the output register is free.
// ----------------------------------------------------------------------------
module bounded_displacement_stream_sorter_unit
    import bdss_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    out_t                  m_data_reg;
    out_t                  m_data_next;
    logic [DATA_WIDTH-1:0] prev_reg;
    logic [DATA_WIDTH-1:0] prev_next;
    logic                  have_reg;
    logic                  have_next;

    cell_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] new_key;
    entry_t                cur   [WINDOW];
    entry_t                ins   [WINDOW];
    logic                  gt    [WINDOW];

    logic                  slot_free;
    logic                  accept;
    logic                  emit;
    logic                  emit_last;
    logic [DATA_WIDTH-1:0] emit_key;

    assign new_key   = to_key(s_data.value);
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++) begin : g_cell
            entry_t left_cur_w;
            logic   left_gt_w;
            entry_t right_ins_w;
            if (i == 0) begin : g_head
                assign left_cur_w = '0;
                assign left_gt_w  = 1'b0;
            end else begin : g_body
                assign left_cur_w = cur[i-1];
                assign left_gt_w  = gt[i-1];
            end
            if (i == WINDOW - 1) begin : g_tail
                assign right_ins_w = '0;
            end else begin : g_mid
                assign right_ins_w = ins[i+1];
            end
            bdss_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .new_key   (new_key),
                .left_cur  (left_cur_w),
                .left_gt   (left_gt_w),
                .right_ins (right_ins_w),
                .cur       (cur[i]),
                .gt        (gt[i]),
                .ins       (ins[i])
            );
        end
    endgenerate

    always_comb begin
        ctl        = '0;
        state_next = state_reg;
        emit       = 1'b0;
        emit_last  = 1'b0;
        emit_key   = ins[0].key;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctl.en     = 1'b1;
                    ctl.ins_en = 1'b1;
                    if (s_data.last_in) begin
                        state_next = ST_FLUSH;
                    end else if (cur[WINDOW-2].valid) begin
                        ctl.shift = 1'b1;
                        emit      = 1'b1;
                        emit_key  = ins[0].key;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    ctl.en    = 1'b1;
                    ctl.shift = 1'b1;
                    emit      = 1'b1;
                    emit_key  = cur[0].key;
                    emit_last = !cur[1].valid;
                    if (!cur[1].valid) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        prev_next    = prev_reg;
        have_next    = have_reg;
        if (emit) begin
            m_valid_next             = 1'b1;
            m_data_next.sorted_value = signed'(to_key(emit_key));
            m_data_next.last_out     = emit_last;
            m_data_next.order_error  = have_reg && (emit_key < prev_reg);
            prev_next                = emit_key;
            have_next                = !emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            have_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            have_reg    <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        prev_reg   <= prev_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sim/bounded_displacement_stream_sorter_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded-displacement stream sorter testbench
// Sends a short table of directed transactions and then random, nearly
// ordered streams with some noise. Every result is checked against a local
// model of the sorting window. Both channels idle at random, the receiver
// holds off once for a long stretch, and the sender drains between phases.
// ----------------------------------------------------------------------------
module bounded_displacement_stream_sorter_unit_test;
    import bdss_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int N_DIRECTED   = 25;
    localparam int PHASE_ITEMS  = 112;
    localparam int HOLD_CYCLES  = 150;

    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0]        SIGN_FLIP = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam out_t NO_RESULT = '0;

    typedef struct packed {
        in_t  item;
        logic typed;
        out_t result;
    } stim_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    out_t sorted_q [$];
    out_t want;

    logic [DATA_WIDTH-1:0] win_keys [WIN];
    int unsigned           win_fill;
    logic [DATA_WIDTH-1:0] prev_key;
    bit                    prev_valid;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;
    int fail_count    = 0;
    int item_count    = 0;
    int stream_count  = 0;
    int result_count  = 0;
    int flagged_count = 0;
    int cycle_count   = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{'{MAX_VAL, 1'b1}, 1'b1, '{MAX_VAL, 1'b1, 1'b0}},
        '{'{MIN_VAL, 1'b1}, 1'b1, '{MIN_VAL, 1'b1, 1'b0}},
        '{'{32'sd0, 1'b1}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{'{-32'sd1, 1'b1}, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
        '{'{32'sd1000, 1'b0}, 1'b0, NO_RESULT},
        '{'{-32'sd5, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd7, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd7, 1'b0}, 1'b0, NO_RESULT},
        '{'{MAX_VAL, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd3, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd3, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd20, 1'b0}, 1'b0, NO_RESULT},
        '{'{-32'sd100, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd0, 1'b0}, 1'b0, NO_RESULT},
        '{'{-32'sd1, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd64, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd7, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd500, 1'b0}, 1'b0, NO_RESULT},
        '{'{-32'sd7, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd12, 1'b0}, 1'b0, NO_RESULT},
        '{'{MAX_VAL, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd15, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd2, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd50, 1'b0}, 1'b0, NO_RESULT},
        '{'{MIN_VAL, 1'b1}, 1'b0, NO_RESULT}
    };

    bounded_displacement_stream_sorter_unit #(
        .WINDOW(WIN)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void emit_key(input logic [DATA_WIDTH-1:0] key, input bit fin);
        out_t r;
        r.sorted_value = key ^ SIGN_FLIP;
        r.last_out     = fin;
        r.order_error  = prev_valid && (key < prev_key);
        prev_key       = key;
        prev_valid     = 1'b1;
        sorted_q.push_back(r);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] take_lowest();
        logic [DATA_WIDTH-1:0] key;
        key = win_keys[0];
        for (int i = 1; i < win_fill; i++)
            win_keys[i-1] = win_keys[i];
        win_fill--;
        return key;
    endfunction

    function automatic void sort_step(input in_t item);
        logic [DATA_WIDTH-1:0] key;
        int pos;
        key = item.value ^ SIGN_FLIP;
        pos = win_fill;
        while (pos > 0 && win_keys[pos-1] > key) begin
            win_keys[pos] = win_keys[pos-1];
            pos--;
        end
        win_keys[pos] = key;
        win_fill++;
        if (item.last_in) begin
            while (win_fill > 0) begin
                key = take_lowest();
                emit_key(key, win_fill == 0);
            end
            prev_valid = 1'b0;
        end else if (win_fill >= WIN) begin
            emit_key(take_lowest(), 1'b0);
        end
    endfunction

    task automatic send_item(input in_t item, input logic typed, input out_t typed_res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sort_step(item);
        if (typed) begin
            void'(sorted_q.pop_back());
            sorted_q.push_back(typed_res);
        end
        item_count++;
        if (item.last_in)
            stream_count++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sorted_q.size() != 0) @(posedge aclk);
    endtask

    task automatic run_streams(input int item_goal);
        logic signed [DATA_WIDTH-1:0] vals [$];
        logic signed [DATA_WIDTH-1:0] base;
        logic signed [DATA_WIDTH-1:0] tmp;
        in_t item;
        int sent, kind, len, chunk, max_chunk, stop, k;
        sent = 0;
        while (sent < item_goal) begin
            kind = $urandom_range(0, 9);
            if (kind == 9)
                len = $urandom_range(1, 4);
            else if ($urandom_range(0, 4) == 0)
                len = $urandom_range(WIN, 3 * WIN);
            else
                len = $urandom_range(1, WIN + 5);
            vals.delete();
            base = $signed($urandom) >>> 2;
            for (int i = 0; i < len; i++) begin
                if (kind >= 8) begin
                    vals.push_back($urandom);
                end else begin
                    vals.push_back(base);
                    base = base + $urandom_range(0, 3000);
                end
            end
            // Shuffle inside short runs; one kind uses runs long enough to break the bound.
            if (kind < 8) begin
                max_chunk = (kind == 7) ? 2 * WIN : WIN - 1;
                for (int i = 0; i < len; i += chunk) begin
                    chunk = $urandom_range(1, max_chunk);
                    stop  = (i + chunk < len) ? i + chunk : len;
                    for (int j = stop - 1; j > i; j--) begin
                        k       = $urandom_range(i, j);
                        tmp     = vals[j];
                        vals[j] = vals[k];
                        vals[k] = tmp;
                    end
                end
            end
            for (int i = 0; i < len; i++) begin
                item.value   = vals[i];
                item.last_in = (i == len - 1);
                send_item(item, 1'b0, NO_RESULT);
            end
            sent += len;
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (m_data.order_error)
                flagged_count++;
            if (sorted_q.size() == 0) begin
                $error("unexpected result: sorted_value %0d", m_data.sorted_value);
                fail_count++;
            end else begin
                want = sorted_q.pop_front();
                if (m_data.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, m_data.sorted_value);
                    fail_count++;
                end
                if (m_data.last_out !== want.last_out) begin
                    $error("last_out: expected %0b, got %0b", want.last_out, m_data.last_out);
                    fail_count++;
                end
                if (m_data.order_error !== want.order_error) begin
                    $error("order_error: expected %0b, got %0b",
                           want.order_error, m_data.order_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sorted_q.size());
            $display("** bounded_displacement_stream_sorter_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        win_fill   = 0;
        prev_key   = '0;
        prev_valid = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 62;
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        drain_results();

        run_streams(PHASE_ITEMS);
        drain_results();

        send_idle_pct = 62;
        recv_idle_pct = 33;
        run_streams(PHASE_ITEMS);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        run_streams(PHASE_ITEMS);
        drain_results();

        repeat (WIN + 10) @(posedge aclk);
        $display("Sent %0d transactions in %0d streams with idling on both sides.",
                 item_count, stream_count);
        $display("Checked %0d results, %0d of them flagged out of order.",
                 result_count, flagged_count);
        if (fail_count == 0 && sorted_q.size() == 0) begin
            $display("** bounded_displacement_stream_sorter_unit: PASSED **");
        end else begin
            $display("** bounded_displacement_stream_sorter_unit: FAILED **");
        end
        $finish;
    end

endmodule
